// ===== hw/rtl/tps_pkg.sv =====
// Shared types, widths and constants for the triangle plane setup pipeline.
package tps_pkg;

    localparam int COORD_W = 32;
    localparam int TAG_W   = 24;
    localparam int EDGE_W  = 33;
    localparam int PROD_W  = 66;
    localparam int CROSS_W = 67;
    localparam int MAG_W   = 67;
    localparam int SCL_W   = 31;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int UNIT_W  = 32;
    localparam int OFF_W   = 40;
    localparam int QUO_W   = 62;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 62;
    localparam int DEF_SQRT_PER_STAGE = 2;
    localparam int DEF_DIV_PER_STAGE  = 2;

    localparam logic [UNIT_W-1:0] UNIT_ONE = 32'h4000_0000;
    localparam logic signed [OFF_W-1:0] OFF_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [OFF_W-1:0] OFF_MIN = 40'sh80_0000_0000;

    typedef struct packed {
        logic [TAG_W-1:0]          triangle_tag;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic [TAG_W-1:0]          out_tag;
        logic signed [UNIT_W-1:0]  unit_nx;
        logic signed [UNIT_W-1:0]  unit_ny;
        logic signed [UNIT_W-1:0]  unit_nz;
        logic signed [OFF_W-1:0]   plane_offset;
        logic                      degenerate;
    } t_tri_out;

    // word carried from the normal front end into the sqrt/divide back end
    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic [SCL_W-1:0]          mx;
        logic [SCL_W-1:0]          my;
        logic [SCL_W-1:0]          mz;
        logic [2:0]                neg;
        logic                      degen;
    } t_scaled;

    // per-item side data travelling through the iterative stages
    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic [2:0]                neg;
        logic                      degen;
    } t_side;

endpackage

// ===== hw/rtl/tps_front.sv =====
// Edges, exact cross product, magnitude and power-of-two scaling, pipelined.
module tps_front
    import tps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_tri_in  i_data,
    output logic     o_valid,
    output t_scaled  o_data
);

    // stage 1: edges
    logic                      r_v1;
    logic [TAG_W-1:0]          r1_tag;
    logic signed [COORD_W-1:0] r1_ax, r1_ay, r1_az;
    logic signed [EDGE_W-1:0]  r1_e1 [3];
    logic signed [EDGE_W-1:0]  r1_e2 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_tag   <= i_data.triangle_tag;
            r1_ax    <= i_data.a_x;
            r1_ay    <= i_data.a_y;
            r1_az    <= i_data.a_z;
            r1_e1[0] <= EDGE_W'(i_data.c_x) - EDGE_W'(i_data.b_x);
            r1_e1[1] <= EDGE_W'(i_data.c_y) - EDGE_W'(i_data.b_y);
            r1_e1[2] <= EDGE_W'(i_data.c_z) - EDGE_W'(i_data.b_z);
            r1_e2[0] <= EDGE_W'(i_data.a_x) - EDGE_W'(i_data.b_x);
            r1_e2[1] <= EDGE_W'(i_data.a_y) - EDGE_W'(i_data.b_y);
            r1_e2[2] <= EDGE_W'(i_data.a_z) - EDGE_W'(i_data.b_z);
        end
    end

    // stage 2: six 33x33 products
    logic                      r_v2;
    logic [TAG_W-1:0]          r2_tag;
    logic signed [COORD_W-1:0] r2_ax, r2_ay, r2_az;
    logic signed [PROD_W-1:0]  r2_p [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_tag  <= r1_tag;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_az   <= r1_az;
            r2_p[0] <= PROD_W'(r1_e1[1]) * PROD_W'(r1_e2[2]);
            r2_p[1] <= PROD_W'(r1_e1[2]) * PROD_W'(r1_e2[1]);
            r2_p[2] <= PROD_W'(r1_e1[2]) * PROD_W'(r1_e2[0]);
            r2_p[3] <= PROD_W'(r1_e1[0]) * PROD_W'(r1_e2[2]);
            r2_p[4] <= PROD_W'(r1_e1[0]) * PROD_W'(r1_e2[1]);
            r2_p[5] <= PROD_W'(r1_e1[1]) * PROD_W'(r1_e2[0]);
        end
    end

    // stage 3: differences, sign and magnitude
    logic                      r_v3;
    logic [TAG_W-1:0]          r3_tag;
    logic signed [COORD_W-1:0] r3_ax, r3_ay, r3_az;
    logic [MAG_W-1:0]          r3_mg [3];
    logic [2:0]                r3_neg;
    logic signed [CROSS_W-1:0] n_cr [3];

    always_comb begin
        n_cr[0] = CROSS_W'(r2_p[0]) - CROSS_W'(r2_p[1]);
        n_cr[1] = CROSS_W'(r2_p[2]) - CROSS_W'(r2_p[3]);
        n_cr[2] = CROSS_W'(r2_p[4]) - CROSS_W'(r2_p[5]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_tag <= r2_tag;
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_az  <= r2_az;
            for (int k = 0; k < 3; k++) begin
                r3_neg[k] <= n_cr[k][CROSS_W-1];
                r3_mg[k]  <= n_cr[k][CROSS_W-1] ? MAG_W'(-n_cr[k]) : MAG_W'(n_cr[k]);
            end
        end
    end

    // stage 4: leading-one position of the OR of the magnitudes
    logic                      r_v4;
    logic [TAG_W-1:0]          r4_tag;
    logic signed [COORD_W-1:0] r4_ax, r4_ay, r4_az;
    logic [MAG_W-1:0]          r4_mg [3];
    logic [2:0]                r4_neg;
    logic [6:0]                r4_len;
    logic [MAG_W-1:0]          n_or;
    logic [6:0]                n_len;

    always_comb begin
        n_or  = r3_mg[0] | r3_mg[1] | r3_mg[2];
        n_len = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (n_or[k]) n_len = 7'(k + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_tag <= r3_tag;
            r4_ax  <= r3_ax;
            r4_ay  <= r3_ay;
            r4_az  <= r3_az;
            r4_mg  <= r3_mg;
            r4_neg <= r3_neg;
            r4_len <= n_len;
        end
    end

    // stage 5: scale so the largest magnitude sits in [2^30, 2^31)
    logic    r_v5;
    t_scaled r5;
    logic [SCL_W-1:0] n_m [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r4_len > 7'd31) begin
                n_m[k] = SCL_W'(r4_mg[k] >> (r4_len - 7'd31));
            end else begin
                n_m[k] = SCL_W'(r4_mg[k] << (7'd31 - r4_len));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5.tag   <= r4_tag;
            r5.a_x   <= r4_ax;
            r5.a_y   <= r4_ay;
            r5.a_z   <= r4_az;
            r5.mx    <= n_m[0];
            r5.my    <= n_m[1];
            r5.mz    <= n_m[2];
            r5.neg   <= r4_neg;
            r5.degen <= (r4_len == 7'd0);
        end
    end

    assign o_valid = r_v5;
    assign o_data  = r5;

endmodule

// ===== hw/rtl/tps_sqrt.sv =====
// Pipelined sum of squares and restoring integer square root.
module tps_sqrt
    import tps_pkg::*;
#(
    parameter int PER_STAGE = DEF_SQRT_PER_STAGE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_scaled          i_data,
    output logic             o_valid,
    output t_side            o_side,
    output logic [SCL_W-1:0] o_m [3],
    output logic [ROOT_W-1:0] o_root
);

    localparam int NST = (SQRT_STEPS + PER_STAGE - 1) / PER_STAGE;

    // square stage
    logic             r_vs;
    t_side            r_ss;
    logic [SCL_W-1:0] r_sm [3];
    logic [SUM_W-1:0] r_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
        end else if (i_en) begin
            r_vs <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ss.tag   <= i_data.tag;
            r_ss.a_x   <= i_data.a_x;
            r_ss.a_y   <= i_data.a_y;
            r_ss.a_z   <= i_data.a_z;
            r_ss.neg   <= i_data.neg;
            r_ss.degen <= i_data.degen;
            r_sm[0] <= i_data.mx;
            r_sm[1] <= i_data.my;
            r_sm[2] <= i_data.mz;
            r_sq[0] <= SUM_W'(i_data.mx) * SUM_W'(i_data.mx);
            r_sq[1] <= SUM_W'(i_data.my) * SUM_W'(i_data.my);
            r_sq[2] <= SUM_W'(i_data.mz) * SUM_W'(i_data.mz);
        end
    end

    // root stages: remainder, partial root; digit steps from the top
    logic              r_v   [NST+1];
    t_side             r_sd  [NST+1];
    logic [SCL_W-1:0]  r_m   [NST+1][3];
    logic [SUM_W-1:0]  r_rad [NST+1];
    logic [SUM_W+1:0]  r_rem [NST+1];
    logic [ROOT_W-1:0] r_rt  [NST+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r_vs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0]  <= r_ss;
            r_m[0]   <= r_sm;
            r_rad[0] <= r_sq[0] + r_sq[1] + r_sq[2];
            r_rem[0] <= '0;
            r_rt[0]  <= '0;
        end
    end

    for (genvar g = 0; g < NST; g++) begin : g_st
        logic [SUM_W+1:0]  n_rem;
        logic [ROOT_W-1:0] n_rt;
        logic [SUM_W+1:0]  n_trial;
        always_comb begin
            n_rem = r_rem[g];
            n_rt  = r_rt[g];
            n_trial = '0;
            for (int k = 0; k < PER_STAGE; k++) begin
                if (g * PER_STAGE + k < SQRT_STEPS) begin
                    n_rem = {n_rem[SUM_W-1:0],
                             r_rad[g][SUM_W-1-2*(g*PER_STAGE+k) -: 2]};
                    n_trial = {(SUM_W-ROOT_W)'(0), n_rt, 2'b01};
                    if (n_rem >= n_trial) begin
                        n_rem = n_rem - n_trial;
                        n_rt  = {n_rt[ROOT_W-2:0], 1'b1};
                    end else begin
                        n_rt  = {n_rt[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[g+1]  <= r_sd[g];
                r_m[g+1]   <= r_m[g];
                r_rad[g+1] <= r_rad[g];
                r_rem[g+1] <= n_rem;
                r_rt[g+1]  <= n_rt;
            end
        end
    end

    assign o_valid = r_v[NST];
    assign o_side  = r_sd[NST];
    assign o_m     = r_m[NST];
    assign o_root  = r_rt[NST];

endmodule

// ===== hw/rtl/tps_div.sv =====
// Three lane restoring divider for rounded m * 2^30 / root, one bit per step.
module tps_div
    import tps_pkg::*;
#(
    parameter int PER_STAGE = DEF_DIV_PER_STAGE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [SCL_W-1:0]  i_m [3],
    input  logic [ROOT_W-1:0] i_root,
    output logic              o_valid,
    output t_side             o_side,
    output logic [QUO_W-1:0]  o_q [3]
);

    localparam int NST = (DIV_STEPS + PER_STAGE - 1) / PER_STAGE;

    logic              r_v   [NST+1];
    t_side             r_sd  [NST+1];
    logic [ROOT_W-1:0] r_dv  [NST+1];
    logic [QUO_W-1:0]  r_num [NST+1][3];
    logic [ROOT_W:0]   r_rem [NST+1][3];
    logic [QUO_W-1:0]  r_q   [NST+1][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    // numerator (m << 30) + root/2 fits 62 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            r_dv[0] <= i_root;
            for (int k = 0; k < 3; k++) begin
                r_num[0][k] <= {i_m[k], 31'd0} + QUO_W'(i_root >> 1) - QUO_W'({i_m[k], 30'd0});
                r_rem[0][k] <= '0;
                r_q[0][k]   <= '0;
            end
        end
    end

    for (genvar g = 0; g < NST; g++) begin : g_st
        logic [ROOT_W:0]  n_rem [3];
        logic [QUO_W-1:0] n_q   [3];
        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_rem[l] = r_rem[g][l];
                n_q[l]   = r_q[g][l];
                for (int k = 0; k < PER_STAGE; k++) begin
                    if (g * PER_STAGE + k < DIV_STEPS) begin
                        n_rem[l] = {n_rem[l][ROOT_W-1:0],
                                    r_num[g][l][QUO_W-1-(g*PER_STAGE+k)]};
                        if (n_rem[l] >= {1'b0, r_dv[g]}) begin
                            n_rem[l] = n_rem[l] - {1'b0, r_dv[g]};
                            n_q[l]   = {n_q[l][QUO_W-2:0], 1'b1};
                        end else begin
                            n_q[l]   = {n_q[l][QUO_W-2:0], 1'b0};
                        end
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[g+1]  <= r_sd[g];
                r_dv[g+1]  <= r_dv[g];
                r_num[g+1] <= r_num[g];
                r_rem[g+1] <= n_rem;
                r_q[g+1]   <= n_q;
            end
        end
    end

    assign o_valid = r_v[NST];
    assign o_side  = r_sd[NST];
    assign o_q     = r_q[NST];

endmodule

// ===== hw/rtl/tps_offset.sv =====
// Clamp, sign the unit normal, dot with the first vertex, round and saturate.
module tps_offset
    import tps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_side            i_side,
    input  logic [QUO_W-1:0] i_q [3],
    output logic             o_valid,
    output t_tri_out         o_data
);

    // stage A: clamp and sign
    logic                     r_va;
    t_side                    r_sa;
    logic signed [UNIT_W-1:0] r_u [3];
    logic signed [UNIT_W-1:0] n_u [3];
    logic [UNIT_W-1:0]        n_mag;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag = (i_q[k] > QUO_W'(UNIT_ONE)) ? UNIT_ONE : UNIT_W'(i_q[k]);
            if (i_side.degen) n_u[k] = '0;
            else n_u[k] = i_side.neg[k] ? -$signed(n_mag) : $signed(n_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sa <= i_side;
            r_u  <= n_u;
        end
    end

    // stage B: three 32x32 products
    logic                     r_vb;
    t_side                    r_sb;
    logic signed [UNIT_W-1:0] r_ub [3];
    logic signed [63:0]       r_p  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb    <= r_sa;
            r_ub    <= r_u;
            r_p[0]  <= 64'(r_u[0]) * 64'(r_sa.a_x);
            r_p[1]  <= 64'(r_u[1]) * 64'(r_sa.a_y);
            r_p[2]  <= 64'(r_u[2]) * 64'(r_sa.a_z);
        end
    end

    // stage C: negate, round, saturate
    logic               r_vc;
    t_tri_out           r_out;
    logic signed [65:0] n_neg;
    logic signed [65:0] n_sh;
    logic signed [OFF_W-1:0] n_off;

    always_comb begin
        n_neg = -(66'(r_p[0]) + 66'(r_p[1]) + 66'(r_p[2])) + 66'sd536870912;
        n_sh  = n_neg >>> 30;
        if (n_sh > 66'(OFF_MAX)) n_off = OFF_MAX;
        else if (n_sh < 66'(OFF_MIN)) n_off = OFF_MIN;
        else n_off = OFF_W'(n_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.out_tag      <= r_sb.tag;
            r_out.unit_nx      <= r_ub[0];
            r_out.unit_ny      <= r_ub[1];
            r_out.unit_nz      <= r_ub[2];
            r_out.plane_offset <= r_sb.degen ? '0 : n_off;
            r_out.degenerate   <= r_sb.degen;
        end
    end

    assign o_valid = r_vc;
    assign o_data  = r_out;

endmodule

// ===== hw/rtl/triangle_plane_setup_top.sv =====
// By default each root stage takes two root digits and each divider stage takes two
// quotient bits.
// Throughput: one triangle per cycle; the whole pipe advances when the output
// register is empty or being read, so a stall holds every stage in place.
// Reset (synchronous, active low) clears the valid bits only.
module triangle_plane_setup_top
    import tps_pkg::*;
#(
    parameter int SQRT_PER_STAGE = DEF_SQRT_PER_STAGE,
    parameter int DIV_PER_STAGE  = DEF_DIV_PER_STAGE
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_tri_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_tri_out o_data
);

    logic              w_en;
    logic              w_fv, w_sv, w_dv;
    t_scaled           w_fd;
    t_side             w_ss, w_ds;
    logic [SCL_W-1:0]  w_m [3];
    logic [ROOT_W-1:0] w_root;
    logic [QUO_W-1:0]  w_q [3];

    // pipe moves unless the final word is held
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    tps_front u_front (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(i_valid && w_en), .i_data,
        .o_valid(w_fv), .o_data(w_fd)
    );

    tps_sqrt #(.PER_STAGE(SQRT_PER_STAGE)) u_sqrt (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(w_fv), .i_data(w_fd),
        .o_valid(w_sv), .o_side(w_ss), .o_m(w_m), .o_root(w_root)
    );

    tps_div #(.PER_STAGE(DIV_PER_STAGE)) u_div (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(w_sv), .i_side(w_ss), .i_m(w_m), .i_root(w_root),
        .o_valid(w_dv), .o_side(w_ds), .o_q(w_q)
    );

    tps_offset u_off (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(w_dv), .i_side(w_ds), .i_q(w_q),
        .o_valid, .o_data
    );

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word changed under stall");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |-> o_data.unit_nx == '0
            && o_data.unit_ny == '0 && o_data.unit_nz == '0
            && o_data.plane_offset == '0)
        else $error("degenerate word carries nonzero fields");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked while output empty");

endmodule
